FILE: design/assert_macros.svh
// assertion macros used by the top level design file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_AT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, expr, msg) \
  `ASSERT_AT(lbl, clk_sig, rst_sig, !(expr), msg)

`endif

FILE: design/pwmpl_pkg.sv
// shared types and constants of the pwm pulse train limiter
// no dependencies
`default_nettype none

package pwmpl_pkg;

  localparam int FREQ_W   = 19;
  localparam int PERIOD_W = 16;
  localparam int DUTY_W   = 7;
  localparam int COUNT_W  = 16;
  localparam int ACTION_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;
  localparam logic [DUTY_W-1:0]   PERCENT_FULL = 7'd100;

  // k * period < 2^23; floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for such x
  localparam int PROD_W      = DUTY_W + PERIOD_W;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  localparam logic [ACTION_W-1:0] ACT_SEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STOP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

FILE: design/pwm_pulse_train_limiter.sv
// top level: pwm compare value with a pulse count limit
// depends on pwmpl_pkg, pwmpl_div, assert_macros.svh
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | action, duty_percent, keep_duty, send_limit
//  out      | out_valid / out_ready | compare_value, pulse_count, sending, train_done
//  cfg      | cfg_write             | cfg_data (output frequency in Hz)
//
// one beat per cycle while in_ready is high; each beat's result comes from the output register in the next cycle
// after a send beat in_ready drops while the duty-to-compare product pipeline (multiply into
// prod, then reciprocal multiply by 1/100 into pending_compare) refills
// a frequency write runs the bit-serial divider and holds in_ready low until it finishes
// reset is synchronous; in_ready rises once prod_fresh and then cmp_fresh have set after reset releases
// the output register holds while out_ready is low and new beats wait behind it
`default_nettype none
`include "assert_macros.svh"

module pwm_pulse_train_limiter #(
  parameter int TICK_RATE_HZ = 1000000
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_write,
  input  wire  [pwmpl_pkg::FREQ_W-1:0]          cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [pwmpl_pkg::ACTION_W-1:0]        action,
  input  wire  [pwmpl_pkg::DUTY_W-1:0]          duty_percent,
  input  wire                                   keep_duty,
  input  wire  [pwmpl_pkg::COUNT_W-1:0]         send_limit,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [pwmpl_pkg::PERIOD_W-1:0]        compare_value,
  output logic [pwmpl_pkg::COUNT_W-1:0]         pulse_count,
  output logic                                  sending,
  output logic                                  train_done
);

  localparam int PW = pwmpl_pkg::PERIOD_W;
  localparam int NW = pwmpl_pkg::COUNT_W;
  localparam int DUW = pwmpl_pkg::DUTY_W;
  localparam int XW = pwmpl_pkg::PROD_W + pwmpl_pkg::RECIP_W;
  localparam int RESET_PERIOD_FULL = TICK_RATE_HZ / 1000;
  localparam logic [PW-1:0] RESET_PERIOD =
    (RESET_PERIOD_FULL > 65535) ? pwmpl_pkg::PERIOD_MAX : PW'(RESET_PERIOD_FULL);

  pwmpl_pkg::div_status_t div_st;
  logic [PW-1:0] div_period;

  logic [PW-1:0]  period_counts;
  logic [PW-1:0]  compare_reg;
  logic           send_pending;
  logic [DUW-1:0] pending_duty;
  logic           pending_keep;
  logic [NW-1:0]  pulse_limit;
  logic [NW-1:0]  pulse_counter;

  logic [pwmpl_pkg::PROD_W-1:0] prod;
  logic [PW-1:0]                pending_compare;
  logic                         prod_fresh;
  logic                         cmp_fresh;

  logic [PW-1:0]  compare_next;
  logic           send_pending_next;
  logic [DUW-1:0] pending_duty_next;
  logic           pending_keep_next;
  logic [NW-1:0]  pulse_limit_next;
  logic [NW-1:0]  pulse_counter_next;
  logic           done_next;

  logic           accept;
  logic           stale;
  logic [DUW-1:0] duty_clamped;
  logic [DUW-1:0] low_percent;
  logic [XW-1:0]  recip_prod;

  pwmpl_div #(
    .TICK_RATE_HZ(TICK_RATE_HZ)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_write),
    .divisor(cfg_data),
    .status (div_st),
    .period (div_period)
  );

  assign in_ready = !div_st.busy && !div_st.done && cmp_fresh && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  // a send beat, which loads the pending duty, or anything that changes the period restarts the product pipeline
  assign stale    = (accept && action == pwmpl_pkg::ACT_SEND) || cfg_write
                    || div_st.busy || div_st.done;

  always_comb begin
    duty_clamped = (pending_duty > pwmpl_pkg::PERCENT_FULL) ? pwmpl_pkg::PERCENT_FULL
                                                            : pending_duty;
    low_percent  = pwmpl_pkg::PERCENT_FULL - duty_clamped;
    recip_prod   = XW'(prod) * XW'(pwmpl_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    prod            <= pwmpl_pkg::PROD_W'(low_percent) * pwmpl_pkg::PROD_W'(period_counts);
    pending_compare <= recip_prod[pwmpl_pkg::RECIP_SHIFT +: PW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_fresh <= 1'b0;
      cmp_fresh  <= 1'b0;
    end else begin
      prod_fresh <= !stale;
      cmp_fresh  <= prod_fresh && !stale;
    end
  end

  always_comb begin
    compare_next       = compare_reg;
    send_pending_next  = send_pending;
    pending_duty_next  = pending_duty;
    pending_keep_next  = pending_keep;
    pulse_limit_next   = pulse_limit;
    pulse_counter_next = pulse_counter;
    done_next          = 1'b0;
    unique case (action)
      pwmpl_pkg::ACT_SEND: begin
        send_pending_next  = 1'b1;
        pending_duty_next  = duty_percent;
        pending_keep_next  = keep_duty;
        pulse_counter_next = NW'(1);
        pulse_limit_next   = send_limit;
      end
      pwmpl_pkg::ACT_STOP: begin
        compare_next       = period_counts;
        pulse_counter_next = '0;
        pulse_limit_next   = '0;
        send_pending_next  = 1'b0;
        pending_duty_next  = '0;
        pending_keep_next  = 1'b0;
      end
      pwmpl_pkg::ACT_TICK: begin
        if (!send_pending && pulse_limit != '0) begin
          if (pulse_counter >= pulse_limit) begin
            compare_next       = period_counts;
            pulse_counter_next = '0;
            pulse_limit_next   = '0;
            done_next          = 1'b1;
          end else begin
            pulse_counter_next = pulse_counter + NW'(1);
          end
        end
        if (send_pending) begin
          if (!pending_keep) begin
            compare_next = pending_compare;
          end
          send_pending_next = 1'b0;
          pending_duty_next = '0;
          pending_keep_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_counts <= RESET_PERIOD;
      compare_reg   <= RESET_PERIOD;
      send_pending  <= 1'b0;
      pending_duty  <= '0;
      pending_keep  <= 1'b0;
      pulse_limit   <= '0;
      pulse_counter <= '0;
    end else if (div_st.done) begin
      // new frequency: output forced low, send state untouched
      period_counts <= div_period;
      compare_reg   <= div_period;
    end else if (accept) begin
      compare_reg   <= compare_next;
      send_pending  <= send_pending_next;
      pending_duty  <= pending_duty_next;
      pending_keep  <= pending_keep_next;
      pulse_limit   <= pulse_limit_next;
      pulse_counter <= pulse_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      compare_value <= compare_next;
      pulse_count   <= pulse_counter_next;
      sending       <= send_pending_next || (pulse_counter_next != '0);
      train_done    <= done_next;
    end
  end

  `ASSERT_NEVER(a_no_beat_while_div, clk, rst, div_st.busy && in_ready, "beat taken during divide")
  `ASSERT_AT(a_send_holds, clk, rst, accept && action == pwmpl_pkg::ACT_SEND |=> !in_ready, "send beat not followed by refill")
  `ASSERT_AT(a_done_idle, clk, rst, out_valid && train_done |-> !sending && pulse_count == '0, "finished train still counting")
  `ASSERT_AT(a_cfg_low, clk, rst, div_st.done |=> compare_reg == period_counts, "frequency write left output driven")

endmodule

`default_nettype wire

FILE: design/pwmpl_div.sv
// iterative restoring divider: period = tick rate / frequency, clamped to 16 bits
// depends on pwmpl_pkg
`default_nettype none

module pwmpl_div #(
  parameter int TICK_RATE_HZ = 1000000
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire  [pwmpl_pkg::FREQ_W-1:0]       divisor,
  output pwmpl_pkg::div_status_t             status,
  output logic [pwmpl_pkg::PERIOD_W-1:0]     period
);

  localparam int DW = $clog2(TICK_RATE_HZ + 1);
  localparam int CW = $clog2(DW + 1);
  localparam int FW = pwmpl_pkg::FREQ_W;
  localparam int PW = pwmpl_pkg::PERIOD_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] num;
  logic [FW-1:0] rem;
  logic [FW-1:0] den;

  logic [FW:0]   rem_sh;
  logic          ge;
  logic [FW:0]   rem_sub;
  logic [DW-1:0] quo_full;
  logic          last;

  always_comb begin
    rem_sh   = {rem, num[DW-1]};
    ge       = rem_sh >= {1'b0, den};
    rem_sub  = rem_sh - {1'b0, den};
    quo_full = {num[DW-2:0], ge};
    last     = cnt == CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last && !start;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CW'(DW);
      num <= DW'(TICK_RATE_HZ);
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      num <= quo_full;
      rem <= ge ? rem_sub[FW-1:0] : rem_sh[FW-1:0];
      if (last) begin
        // zero frequency and over-long periods both saturate
        if (den == '0 || 32'(quo_full) > 32'(pwmpl_pkg::PERIOD_MAX)) begin
          period <= pwmpl_pkg::PERIOD_MAX;
        end else begin
          period <= PW'(quo_full);
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire
